FILE: src/ntl_pkg.sv
// Shared types and constants for the NDEF TLV locator.
// No dependencies; used by ntl_result_if, ntl_core and ndef_tlv_locator.
package ntl_pkg;

  localparam int POS_W        = 13;   // width of every reported offset
  localparam int LEN_W        = 16;   // full TLV length field
  localparam int MAX_AREA_DEF = 4096;

  localparam logic [7:0] BYTE_PAD  = 8'h00;
  localparam logic [7:0] BYTE_NDEF = 8'h03;
  localparam logic [7:0] BYTE_TERM = 8'hFE;
  localparam logic [7:0] BYTE_LONG = 8'hFF;

  typedef enum logic [1:0] {
    ST_FOUND       = 2'd0,
    ST_NO_NDEF     = 2'd1,
    ST_TRUNC_NDEF  = 2'd2,
    ST_TRUNC_AFTER = 2'd3
  } ntl_status_t;

  typedef struct packed {
    ntl_status_t        status;
    logic [POS_W-1:0]   tlv_start;
    logic [POS_W-1:0]   value_start;
    logic [POS_W-1:0]   value_len;
    logic [POS_W-1:0]   tlv_end;
    logic [POS_W-1:0]   stream_end;
  } ntl_result_t;

endpackage

FILE: src/ntl_byte_if.sv
// Valid/ready channel carrying one byte of the tag data area per beat.
// Depends on nothing.
interface ntl_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

FILE: src/ntl_result_if.sv
// Valid/ready channel carrying one locator result per beat.
// Depends on ntl_pkg for the offset width.
interface ntl_result_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                status;
  logic [ntl_pkg::POS_W-1:0] tlv_start;
  logic [ntl_pkg::POS_W-1:0] value_start;
  logic [ntl_pkg::POS_W-1:0] value_len;
  logic [ntl_pkg::POS_W-1:0] tlv_end;
  logic [ntl_pkg::POS_W-1:0] stream_end;

  modport source (output valid, output status, output tlv_start, output value_start,
                  output value_len, output tlv_end, output stream_end, input ready);
  modport sink   (input valid, input status, input tlv_start, input value_start,
                  input value_len, input tlv_end, input stream_end, output ready);
endinterface

FILE: src/ntl_core.sv
// TLV walker: consumes one byte per enabled cycle and produces the area result
// combinationally on the final byte. Depends on ntl_pkg.
module ntl_core #(
  parameter int MAX_AREA = ntl_pkg::MAX_AREA_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic [7:0]           data_byte,
  input  logic                 last_byte,
  output ntl_pkg::ntl_result_t res
);
  import ntl_pkg::*;

  localparam int CW = $clog2(MAX_AREA + 1);

  typedef enum logic [2:0] {
    PH_TYPE, PH_LEN, PH_LENHI, PH_LENLO, PH_VALUE, PH_DONE
  } phase_t;

  phase_t           phase, phase_next;
  logic [CW-1:0]    byte_position, byte_position_next;
  logic [7:0]       length_high, length_high_next;
  logic [LEN_W-1:0] remaining, remaining_next;
  logic             cur_ndef, cur_ndef_next;
  logic             found, found_next;
  logic             over_area, over_area_next;
  logic [POS_W-1:0] tlv_start, tlv_start_next;
  logic [POS_W-1:0] value_start, value_start_next;
  logic [POS_W-1:0] value_len, value_len_next;
  logic [POS_W-1:0] stream_end, stream_end_next;

  logic             in_range;
  logic [POS_W-1:0] pos;
  logic             vb_go;
  logic [LEN_W-1:0] vb_len;

  assign in_range = byte_position < CW'(MAX_AREA);
  assign pos      = POS_W'(byte_position);

  always_comb begin
    phase_next         = phase;
    byte_position_next = byte_position;
    length_high_next   = length_high;
    remaining_next     = remaining;
    cur_ndef_next      = cur_ndef;
    found_next         = found;
    over_area_next     = over_area;
    tlv_start_next     = tlv_start;
    value_start_next   = value_start;
    value_len_next     = value_len;
    stream_end_next    = stream_end;
    vb_go              = 1'b0;
    vb_len             = '0;
    res                = '0;

    if (en) begin
      if (in_range) begin
        byte_position_next = byte_position + 1'b1;
        unique case (phase)
          PH_TYPE: begin
            if (data_byte == BYTE_TERM) begin
              if (found) stream_end_next = pos + 1'b1;
              phase_next = PH_DONE;
            end else if (data_byte != BYTE_PAD) begin
              cur_ndef_next = (data_byte == BYTE_NDEF) && !found;
              if ((data_byte == BYTE_NDEF) && !found) tlv_start_next = pos;
              phase_next = PH_LEN;
            end
          end
          PH_LEN: begin
            if (data_byte == BYTE_LONG) begin
              phase_next = PH_LENHI;
            end else begin
              vb_go  = 1'b1;
              vb_len = {8'h00, data_byte};
            end
          end
          PH_LENHI: begin
            length_high_next = data_byte;
            phase_next       = PH_LENLO;
          end
          PH_LENLO: begin
            vb_go  = 1'b1;
            vb_len = {length_high, data_byte};
          end
          PH_VALUE: begin
            remaining_next = remaining - 1'b1;
            if (remaining == LEN_W'(1)) begin
              if (cur_ndef) begin
                found_next    = 1'b1;
                cur_ndef_next = 1'b0;
              end
              phase_next = PH_TYPE;
            end
          end
          PH_DONE: begin
            phase_next = PH_DONE;
          end
          default: phase_next = PH_TYPE;
        endcase

        // value field starts after the length bytes
        if (vb_go) begin
          if (cur_ndef) begin
            value_start_next = pos + 1'b1;
            value_len_next   = vb_len[POS_W-1:0];
          end
          remaining_next = vb_len;
          if (vb_len == '0) begin
            if (cur_ndef) begin
              found_next    = 1'b1;
              cur_ndef_next = 1'b0;
            end
            phase_next = PH_TYPE;
          end else begin
            phase_next = PH_VALUE;
          end
        end
      end else begin
        over_area_next = 1'b1;
      end

      if (last_byte) begin
        if (over_area_next) begin
          res.status = ST_TRUNC_NDEF;
        end else if (phase_next == PH_TYPE || phase_next == PH_DONE) begin
          res.status = found_next ? ST_FOUND : ST_NO_NDEF;
          if (found_next && phase_next == PH_TYPE)
            stream_end_next = POS_W'(byte_position_next);
        end else begin
          res.status = found_next ? ST_TRUNC_AFTER : ST_TRUNC_NDEF;
        end

        if (res.status == ST_FOUND) begin
          res.tlv_start   = tlv_start_next;
          res.value_start = value_start_next;
          res.value_len   = value_len_next;
          res.tlv_end     = value_start_next + value_len_next;
          res.stream_end  = stream_end_next;
        end

        // start over for the next area
        phase_next         = PH_TYPE;
        byte_position_next = '0;
        length_high_next   = '0;
        remaining_next     = '0;
        cur_ndef_next      = 1'b0;
        found_next         = 1'b0;
        over_area_next     = 1'b0;
        tlv_start_next     = '0;
        value_start_next   = '0;
        value_len_next     = '0;
        stream_end_next    = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_TYPE;
      byte_position <= '0;
      length_high   <= '0;
      remaining     <= '0;
      cur_ndef      <= 1'b0;
      found         <= 1'b0;
      over_area     <= 1'b0;
      tlv_start     <= '0;
      value_start   <= '0;
      value_len     <= '0;
      stream_end    <= '0;
    end else begin
      phase         <= phase_next;
      byte_position <= byte_position_next;
      length_high   <= length_high_next;
      remaining     <= remaining_next;
      cur_ndef      <= cur_ndef_next;
      found         <= found_next;
      over_area     <= over_area_next;
      tlv_start     <= tlv_start_next;
      value_start   <= value_start_next;
      value_len     <= value_len_next;
      stream_end    <= stream_end_next;
    end
  end

endmodule

FILE: src/ndef_tlv_locator.sv
// NDEF TLV locator top level: input register, TLV walker, result register.
// Depends on ntl_pkg, ntl_byte_if, ntl_result_if and ntl_core.
//
// Usage:
//   bytes  : one byte of a tag data area per beat, last_byte set on the final
//            byte of the area. Areas follow each other with no gap.
//   result : one beat per area: status plus the NDEF TLV offsets, value length,
//            end of the NDEF value and stream end. Offsets are zero unless the
//            status is "found".
// Timing:
//   One byte per clock sustained while no result waits on result.ready. A byte
//   is captured in the input register, then the walker updates its state; the
//   result register captures the result beat from the walker on the final byte.
//   The rate is set by the walker state update, which is combinational.
// Stall:
//   While a result waits on result.ready, the byte in the input register holds
//   and bytes.ready drops once that register is full; nothing is dropped.
// Reset:
//   rst (synchronous) empties both registers and returns the walker to the
//   start of an area. No setup pass is needed after reset.
module ndef_tlv_locator #(
  parameter int MAX_AREA = ntl_pkg::MAX_AREA_DEF
) (
  input logic          clk,
  input logic          rst,
  ntl_byte_if.sink     bytes,
  ntl_result_if.source result
);
  import ntl_pkg::*;

  logic        in_valid;
  logic [7:0]  in_data;
  logic        in_last;
  logic        advance;
  logic        step;
  logic        out_valid;
  ntl_result_t out_res;
  ntl_result_t core_res;

  assign advance     = !out_valid || result.ready;
  assign step        = in_valid && advance;
  assign bytes.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (bytes.valid && bytes.ready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
    if (bytes.valid && bytes.ready) begin
      in_data <= bytes.data_byte;
      in_last <= bytes.last_byte;
    end
  end

  ntl_core #(
    .MAX_AREA (MAX_AREA)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .en        (step),
    .data_byte (in_data),
    .last_byte (in_last),
    .res       (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step && in_last) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
    if (step && in_last) out_res <= core_res;
  end

  assign result.valid       = out_valid;
  assign result.status      = out_res.status;
  assign result.tlv_start   = out_res.tlv_start;
  assign result.value_start = out_res.value_start;
  assign result.value_len   = out_res.value_len;
  assign result.tlv_end     = out_res.tlv_end;
  assign result.stream_end  = out_res.stream_end;

endmodule
